// File: rtl/tcpq_pkg.sv
// Shared types and constants for the two-class process queue.
// Holds request and status codes, field widths and the FIFO control word.
// No dependencies.
package tcpq_pkg;

   // Default configuration of the queue.
   localparam int CAPACITY_DEF = 16;
   localparam int ID_BITS_DEF  = 16;

   // Fixed field widths of the request and response words.
   localparam int PROC_ID_W = 16;
   localparam int TOTAL_W   = 5;

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_ADD  = 2'd0,
      REQ_EXEC = 2'd1,
      REQ_END  = 2'd2
   } req_code_type;

   // Completion status codes carried on rsp_status.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Per-cycle command to one class FIFO.
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

// File: rtl/two_class_process_queue.sv
// Top level of the two-class process queue: request register, request
// decode over the priority and common FIFOs, and the response register.
// Depends on tcpq_pkg and tcpq_fifo.
//
// Usage:
//   A request word (req_type, req_proc_id, req_is_priority) is taken at a
//   rising edge where start is high and busy is low. Add appends the id to
//   the priority or common FIFO, execute moves the served head to the
//   common tail, and end removes the served head. The priority FIFO is
//   always served before the common FIFO.
//   Every request gives one response word on the rsp_ ports, marked by
//   rsp_strobe for exactly one cycle. The response passes through the
//   request register and then the decode and response register.
//   A new request can be taken every cycle; each request only touches the
//   FIFO heads and tails, and the next head id is prefetched from the id
//   store, so one word per cycle is sustained.
//   The receiver cannot stall; responses must be taken as they appear.
//   Reset clears both FIFOs and sets busy high; busy goes low once reset
//   is released and stays low after that.
module two_class_process_queue
   import tcpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_BITS  = ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_type,
   input  logic [PROC_ID_W-1:0] req_proc_id,
   input  logic                 req_is_priority,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [PROC_ID_W-1:0] rsp_head_id,
   output logic                 rsp_from_priority,
   output logic [TOTAL_W-1:0]   rsp_total_held
);

   localparam int ID_W  = (ID_BITS < PROC_ID_W) ? ID_BITS : PROC_ID_W;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int TOT_W = CNT_W + 1;

   logic                 busy_ff;
   logic                 vld_ff;
   req_code_type         type_ff;
   logic [ID_W-1:0]      id_ff;
   logic                 prio_ff;

   fifo_ctl_type         p_ctl, c_ctl;
   logic [CNT_W-1:0]     p_count, c_count;
   logic [ID_W-1:0]      p_head, c_head;
   logic [ID_W-1:0]      c_wr_id;

   logic [TOT_W-1:0]     total_now, total_after;
   logic                 full, empty;
   logic [ID_W-1:0]      served;

   status_type           status_in, status_ff;
   logic [PROC_ID_W-1:0] head_id_in, head_id_ff;
   logic                 from_prio_in, from_prio_ff;
   logic [TOTAL_W-1:0]   total_in, total_ff;
   logic                 strobe_ff;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= start && !busy_ff;
      end
      if (start && !busy_ff) begin
         type_ff <= req_code_type'(req_type);
         id_ff   <= ID_W'(req_proc_id);
         prio_ff <= req_is_priority;
      end
   end

   // Occupancy of both classes.
   assign total_now = TOT_W'(p_count) + TOT_W'(c_count);
   assign full      = total_now >= TOT_W'(CAPACITY);
   assign empty     = (p_count == '0) && (c_count == '0);
   assign served    = (p_count != '0) ? p_head : c_head;

   // Request decode: FIFO commands and the response word.
   always_comb begin
      p_ctl        = '0;
      c_ctl        = '0;
      c_wr_id      = id_ff;
      status_in    = ST_OK;
      head_id_in   = '0;
      from_prio_in = 1'b0;
      total_after  = total_now;
      if (vld_ff) begin
         case (type_ff)
            REQ_ADD: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  p_ctl.push  = prio_ff;
                  c_ctl.push  = !prio_ff;
                  total_after = total_now + TOT_W'(1);
               end
            end
            REQ_EXEC, REQ_END: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  p_ctl.pop    = (p_count != '0);
                  c_ctl.pop    = (p_count == '0);
                  head_id_in   = PROC_ID_W'(served);
                  from_prio_in = (p_count != '0);
                  if (type_ff == REQ_EXEC) begin
                     c_ctl.push = 1'b1;
                     c_wr_id    = served;
                  end else begin
                     total_after = total_now - TOT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
      total_in = TOTAL_W'(total_after);
   end

   tcpq_fifo #(
      .CAPACITY (CAPACITY),
      .ID_W     (ID_W)
   ) u_prio (
      .clock   (clock),
      .reset   (reset),
      .ctl     (p_ctl),
      .wr_id   (id_ff),
      .count   (p_count),
      .head_id (p_head)
   );

   tcpq_fifo #(
      .CAPACITY (CAPACITY),
      .ID_W     (ID_W)
   ) u_common (
      .clock   (clock),
      .reset   (reset),
      .ctl     (c_ctl),
      .wr_id   (c_wr_id),
      .count   (c_count),
      .head_id (c_head)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff;
      end
      if (vld_ff) begin
         status_ff    <= status_in;
         head_id_ff   <= head_id_in;
         from_prio_ff <= from_prio_in;
         total_ff     <= total_in;
      end
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_head_id       = head_id_ff;
   assign rsp_from_priority = from_prio_ff;
   assign rsp_total_held    = total_ff;

endmodule

// File: rtl/tcpq_fifo.sv
// One class FIFO of the process queue: circular id store, head pointer,
// fill count and a head-value cache fed by a registered look-ahead read.
// Depends on tcpq_pkg.
module tcpq_fifo
   import tcpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int ID_W     = ID_BITS_DEF,
   localparam int PTR_W   = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  fifo_ctl_type     ctl,
   input  logic [ID_W-1:0]  wr_id,
   output logic [CNT_W-1:0] count,
   output logic [ID_W-1:0]  head_id
);

   localparam int SUM_W = CNT_W + 1;

   logic [ID_W-1:0]  store_ff [CAPACITY];
   logic [ID_W-1:0]  rdata_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ID_W-1:0]  hreg_ff, hreg_in;
   logic             use_rd_ff, use_rd_in;
   logic [PTR_W-1:0] head_nxt;
   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail;
   logic             wr_hit;
   logic [ID_W-1:0]  head_val;

   // Pointer arithmetic with wrap at the capacity.
   assign head_nxt = (head_ff == PTR_W'(CAPACITY - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail     = (tail_sum >= SUM_W'(CAPACITY)) ?
                     PTR_W'(tail_sum - SUM_W'(CAPACITY)) : PTR_W'(tail_sum);

   // The head value is either the look-ahead read or the cached copy.
   assign head_val = use_rd_ff ? rdata_ff : hreg_ff;
   assign wr_hit   = ctl.push && ctl.pop && (tail == head_nxt);

   // Decide where the head value comes from in the next cycle.
   always_comb begin
      hreg_in   = head_val;
      use_rd_in = 1'b0;
      if (ctl.pop) begin
         hreg_in   = wr_id;
         use_rd_in = !wr_hit;
      end else if (ctl.push && (count_ff == '0)) begin
         hreg_in = wr_id;
      end
   end

   // Pointer and fill count updates.
   always_comb begin
      head_in  = ctl.pop ? head_nxt : head_ff;
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         use_rd_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         use_rd_ff <= use_rd_in;
      end
      hreg_ff <= hreg_in;
   end

   // Id store: one write port at the tail, one registered read of the
   // entry behind the head.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         store_ff[tail] <= wr_id;
      end
      rdata_ff <= store_ff[head_nxt];
   end

   assign count   = count_ff;
   assign head_id = head_val;

endmodule

// File: rtl/tcpq_checker.sv
// Port-level checks for the two-class process queue and the bind that
// attaches them to the top level.
// Depends on tcpq_pkg and two_class_process_queue.
module tcpq_checker
   import tcpq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input logic [1:0]           rsp_status,
   input logic [PROC_ID_W-1:0] rsp_head_id,
   input logic                 rsp_from_priority,
   input logic [TOTAL_W-1:0]   rsp_total_held
);

   // Every taken request gives a response after the request and response registers.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request taken without a response two cycles later");

   // No response word appears without a request behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response word without a matching request");

   // An empty report means nothing is held and nothing was served.
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_EMPTY)) |->
         ((rsp_total_held == '0) && (rsp_head_id == '0) && !rsp_from_priority))
      else $error("empty status with held or served ids");

   // Only a successful serve can come from the priority class.
   a_prio_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_from_priority) |-> (rsp_status == ST_OK))
      else $error("priority serve reported with an error status");

endmodule

bind two_class_process_queue tcpq_checker u_tcpq_checker (.*);
